### design/espc_pkg.sv
package espc_pkg;

  localparam int unsigned SET_W = 8;
  localparam int unsigned CNT_W = 30;

  localparam logic [CNT_W-1:0] PRIME_MOD = 30'd1000000007;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CALC  = 7'b0000010,
    ST_CLEAR = 7'b0000100,
    ST_RUN   = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_HALF  = 7'b1000000
  } espc_state_e;

endpackage

### design/equal_sum_partition_counter.sv
// Equal-sum partition counter.
// Command channel: start with set_size_i (n) is taken at a clock edge where
// start is high and busy is low. busy stays high until the result is out.
// Result channel: result_valid_o is high for one cycle with partition_count_o,
// the number of splits of 1..n into two equal-sum sets, modulo 1000000007.
// The receiver cannot stall; the strobe drops after that one cycle.
// Steps, with target m = n(n+1)/4 when n(n+1) is a multiple of 4:
//   check n, clear row entries 0..m, then one pass per i = 1..n issuing
//   updates for j = m down to i and then draining the update pipeline,
//   then read and halve the count.
// Otherwise, or when n exceeds MAX_N, the check of n ends the item with a
// result of zero. One item at a time; the rate is set by the single row
// memory, which takes one read-add-write update per cycle within a pass,
// not while the pipeline drains, through a three-stage pipeline (read,
// add, reduce then write).
// Reset (asynchronous, active low) returns the block to idle with no result
// pending; the row memory needs no clearing since each item clears its own.
module equal_sum_partition_counter
  import espc_pkg::*;
#(
  parameter int unsigned MAX_N = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [SET_W-1:0] set_size_i,
  output logic             result_valid_o,
  output logic [CNT_W-1:0] partition_count_o
);

  localparam int unsigned ROW_LEN = MAX_N * (MAX_N + 1) / 4 + 1;
  localparam int unsigned AW      = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
  localparam int unsigned DW      = (AW > SET_W) ? AW : SET_W;
  localparam int unsigned PW      = 2 * SET_W + 1;

  espc_state_e state_q, state_d;

  logic [SET_W-1:0] n_q;
  logic [SET_W-1:0] i_q, i_d;
  logic [AW-1:0]    j_q, j_d;
  logic [AW-1:0]    target_q, target_d;

  logic [CNT_W-1:0] mem [ROW_LEN];

  logic [CNT_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]    addr1_q, addr2_q, addr3_q;
  logic             v1_q, v2_q, v3_q;
  logic [CNT_W:0]   sum_q;
  logic [CNT_W-1:0] wd_q;

  logic [CNT_W-1:0] result_q, result_d;
  logic             done_q, done_d;

  logic [PW-1:0]    prod;
  logic [AW+PW-3:0] target_ext;
  logic             too_big;
  logic [DW-1:0]    j_ext, i_ext, diff_ext;
  logic [AW-1:0]    addr_a, addr_b;
  logic             issue;
  logic             clr_we;
  logic [CNT_W-1:0] clr_data;
  logic [CNT_W:0]   half_sum;

  assign prod       = {{(SET_W+1){1'b0}}, n_q} * ({{(SET_W+1){1'b0}}, n_q} + PW'(1));
  assign target_ext = {{AW{1'b0}}, prod[PW-1:2]};
  assign too_big    = (32'(n_q) > 32'(MAX_N));

  assign j_ext    = DW'(j_q);
  assign i_ext    = DW'(i_q);
  assign diff_ext = j_ext - i_ext;

  assign issue    = (state_q == ST_RUN) && (j_ext >= i_ext);
  assign addr_a   = (state_q == ST_READ) ? target_q : j_q;
  assign addr_b   = diff_ext[AW-1:0];
  assign clr_we   = (state_q == ST_CLEAR);
  assign clr_data = (j_q == '0) ? CNT_W'(1) : '0;

  // odd counts take the prime before halving
  assign half_sum = rd_a_q[0] ? ({1'b0, rd_a_q} + {1'b0, PRIME_MOD}) : {1'b0, rd_a_q};

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    target_d = target_q;
    result_d = result_q;
    done_d   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        target_d = target_ext[AW-1:0];
        j_d      = '0;
        if (too_big || (prod[1:0] != 2'b00)) begin
          result_d = '0;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (j_q == target_q) begin
          i_d = SET_W'(1);
          j_d = target_q;
          if (n_q == '0) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_RUN;
          end
        end else begin
          j_d = j_q + AW'(1);
        end
      end
      ST_RUN: begin
        if (issue) begin
          j_d = j_q - AW'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // hold until the last write of this pass has landed
        if (!v1_q && !v2_q && !v3_q) begin
          if (i_q == n_q) begin
            state_d = ST_READ;
          end else begin
            i_d     = i_q + SET_W'(1);
            j_d     = target_q;
            state_d = ST_RUN;
          end
        end
      end
      ST_READ: begin
        state_d = ST_HALF;
      end
      ST_HALF: begin
        result_d = half_sum[CNT_W:1];
        done_d   = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start) begin
      n_q <= set_size_i;
    end
    i_q      <= i_d;
    j_q      <= j_d;
    target_q <= target_d;
    result_q <= result_d;
    addr1_q  <= j_q;
    sum_q    <= {1'b0, rd_a_q} + {1'b0, rd_b_q};
    addr2_q  <= addr1_q;
    wd_q     <= (sum_q >= {1'b0, PRIME_MOD}) ? CNT_W'(sum_q - {1'b0, PRIME_MOD})
                                             : sum_q[CNT_W-1:0];
    addr3_q  <= addr2_q;
  end

  // row memory: two registered reads, one write
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
    if (v3_q) begin
      mem[addr3_q] <= wd_q;
    end else if (clr_we) begin
      mem[j_q] <= clr_data;
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign result_valid_o    = done_q;
  assign partition_count_o = result_q;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (partition_count_o < PRIME_MOD))
    else $error("count not reduced");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ((state_q == ST_RUN) || (state_q == ST_DRAIN)))
    else $error("update write outside an update pass");

  a_start_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_CALC))
    else $error("transfer not taken");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (j_q <= target_q))
    else $error("update beyond target");
`endif

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import espc_pkg::*;

  localparam int unsigned MAX_SET = 255;
  localparam int unsigned ROW_DEPTH = MAX_SET * (MAX_SET + 1) / 4 + 1;
  // Slowest item is the full table at MAX_SET, plus clear and drain overhead.
  localparam int unsigned WATCHDOG_LIMIT = 4 * (MAX_SET * ROW_DEPTH + 8 * MAX_SET + 64);
  localparam int unsigned RANDOM_ITEMS = 76;
  localparam int unsigned QUIET_TAIL = 16;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    logic [SET_W-1:0] size;
    bit               hold_for_drain;
  } split_cmd_t;

  typedef struct {
    logic [SET_W-1:0] size;
    logic [CNT_W-1:0] count;
  } split_count_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [SET_W-1:0] set_size_i = '0;
  logic             result_valid_o;
  logic [CNT_W-1:0] partition_count_o;

  split_cmd_t   split_cmds[$];
  split_count_t expected_counts[$];
  logic [CNT_W-1:0] subset_ways [0:ROW_DEPTH-1];

  bit          cmd_taken = 1'b0;
  int unsigned rest_cycles = 0;
  int unsigned issued = 0;
  int unsigned item_total = 0;
  int unsigned idle_cycles = 0;
  int unsigned split_mismatches = 0;

  equal_sum_partition_counter #(
    .MAX_N(MAX_SET)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .set_size_i       (set_size_i),
    .result_valid_o   (result_valid_o),
    .partition_count_o(partition_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Count the unordered equal-sum splits of 1..n with a single subset-sum row.
  function automatic logic [CNT_W-1:0] count_equal_splits(input logic [SET_W-1:0] n);
    int unsigned     size;
    int unsigned     goal;
    logic [CNT_W:0]  acc;
    size = 32'(n);
    if (size > MAX_SET || ((size * (size + 1)) % 4) != 0) return '0;
    goal = size * (size + 1) / 4;
    for (int unsigned j = 0; j <= goal; j++) subset_ways[j] = '0;
    subset_ways[0] = CNT_W'(1);
    for (int unsigned i = 1; i <= size; i++) begin
      for (int unsigned j = goal; j >= i; j--) begin
        acc = {1'b0, subset_ways[j]} + {1'b0, subset_ways[j-i]};
        if (acc >= {1'b0, PRIME_MOD}) acc = acc - {1'b0, PRIME_MOD};
        subset_ways[j] = acc[CNT_W-1:0];
      end
    end
    // Halve modulo the prime: add the prime first when odd.
    acc = {1'b0, subset_ways[goal]};
    if (acc[0]) acc = acc + {1'b0, PRIME_MOD};
    acc = acc >> 1;
    return acc[CNT_W-1:0];
  endfunction

  task automatic queue_split(input logic [SET_W-1:0] size, input bit hold_for_drain);
    split_cmd_t cmd;
    cmd.size = size;
    cmd.hold_for_drain = hold_for_drain;
    split_cmds.push_back(cmd);
  endtask

  // Driver: hold start until the transfer, then maybe rest before the next command.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || cmd_taken) begin
        if (start && issued < item_total - QUIET_TAIL && $urandom_range(0, 2) == 0)
          rest_cycles = $urandom_range(1, 8);
        if (rest_cycles != 0) begin
          rest_cycles = rest_cycles - 1;
          start <= 1'b0;
        end else if (split_cmds.size() == 0 ||
                     (split_cmds[0].hold_for_drain && expected_counts.size() != 0)) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          set_size_i <= split_cmds[0].size;
          split_cmds.pop_front();
          issued = issued + 1;
        end
      end
    end
  end

  // Monitor: predict on each command transfer, check each result strobe.
  always @(posedge clk_i) begin
    split_count_t want;
    if (rst_ni) begin
      cmd_taken <= start && !busy;
      if (start && !busy) begin
        want.size = set_size_i;
        want.count = count_equal_splits(set_size_i);
        expected_counts.push_back(want);
      end
      if (result_valid_o) begin
        if (expected_counts.size() == 0) begin
          split_mismatches = split_mismatches + 1;
          if (split_mismatches <= REPORT_LIMIT)
            $display("unexpected result: partition_count %0d", partition_count_o);
        end else begin
          want = expected_counts.pop_front();
          if (partition_count_o !== want.count) begin
            split_mismatches = split_mismatches + 1;
            if (split_mismatches <= REPORT_LIMIT)
              $display("mismatch: set_size %0d partition_count expected %0d got %0d",
                       want.size, want.count, partition_count_o);
          end
        end
      end
      if ((start && !busy) || result_valid_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("[equal_sum_partition_counter] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned      corner_sizes[$];
    int unsigned      pick;
    logic [SET_W-1:0] size;
    // Zero size, the smallest tables, odd totals with the top bit set, and the largest size.
    corner_sizes = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 11, 12, 15, 16, 23, 24, 31, 32, 64,
                     129, 130, 170, 253, 254, 255};
    foreach (corner_sizes[k]) queue_split(corner_sizes[k][SET_W-1:0], 1'b0);
    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        size = SET_W'($urandom_range(0, 31));
      end else if (pick < 82) begin
        size = SET_W'($urandom_range(32, 63));
      end else begin
        // odd total sum: answer is zero and comes back at once
        size = SET_W'($urandom_range(0, 255));
        size[1:0] = 2'($urandom_range(1, 2));
      end
      queue_split(size, (k % 25) == 0);
    end
    item_total = split_cmds.size();

    @(posedge rst_ni);
    while (split_cmds.size() != 0 || start) @(posedge clk_i);
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (split_mismatches == 0) begin
      $display("[equal_sum_partition_counter] OK");
    end else begin
      $display("[equal_sum_partition_counter] ERROR");
    end
    $finish;
  end

endmodule
